@@ rtl/core/keyframe_aware_frame_queue_top_assert.svh @@
// Assertion macros shared by the frame queue RTL.
`ifndef KEYFRAME_AWARE_FRAME_QUEUE_TOP_ASSERT_SVH
`define KEYFRAME_AWARE_FRAME_QUEUE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Implication property, sampled on clk, off while rst is high.
`define KAFQ_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Plain invariant, sampled on clk, off while rst is high.
`define KAFQ_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`else
`define KAFQ_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define KAFQ_ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`endif

`endif

@@ rtl/core/kafq_pkg.sv @@
package kafq_pkg;

   localparam int KAFQ_DEPTH_DEFAULT = 64;

   localparam logic [30:0] MAX_BYTES_RESET = 31'd1048576;
   localparam logic [7:0]  KEY_FLAG_RESET  = 8'd1;

   // opcodes
   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_CANCEL = 2'd2;

   // register indexes
   localparam logic CSR_MAX_BYTES = 1'b0;
   localparam logic CSR_KEY_FLAG  = 1'b1;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_REJECTED  = 3'd2,
      ST_CANCELLED = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DROP,
      S_PUSH,
      S_FINISH
   } state_type;

   // frame descriptor, handle in the low bits
   typedef struct packed {
      logic [31:0] timestamp;
      logic [7:0]  flag;
      logic [7:0]  kind;
      logic [23:0] size;
      logic [31:0] handle;
   } desc_type;

   typedef struct packed {
      logic       load_req;
      logic       set_status;
      status_type status_code;
      logic       drop;
      logic       push;
      logic       pop;
      logic       clear;
      logic       cancel;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       cancelled;
      logic       empty;
      logic       full;
      logic       over_limit;
      logic       head_key;
      logic       out_busy;
   } stat_type;

endpackage

@@ rtl/core/kafq_ctrl.sv @@
`include "keyframe_aware_frame_queue_top_assert.svh"

module kafq_ctrl
   import kafq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.op == OP_PUSH && !stat.cancelled) begin
               state_in = (!stat.empty && stat.over_limit) ? S_DROP : S_PUSH;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_DROP: begin
            if (stat.empty || (stat.head_key && !stat.over_limit)) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!stat.out_busy) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         S_CHECK: begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_OK;
            case (stat.op)
               OP_PUSH: begin
                  if (stat.cancelled) begin
                     cmd.status_code = ST_REJECTED;
                  end
               end
               OP_POP: begin
                  if (stat.empty) begin
                     if (stat.cancelled) begin
                        cmd.clear       = 1'b1;
                        cmd.status_code = ST_CANCELLED;
                     end else begin
                        cmd.status_code = ST_EMPTY;
                     end
                  end else begin
                     cmd.pop = 1'b1;
                  end
               end
               OP_CANCEL: begin
                  cmd.cancel = 1'b1;
               end
               default: begin
                  cmd.status_code = ST_OK;
               end
            endcase
         end
         S_DROP: begin
            cmd.drop = !stat.empty && (!stat.head_key || stat.over_limit);
         end
         S_PUSH: begin
            cmd.set_status  = 1'b1;
            if (stat.full) begin
               cmd.status_code = ST_FULL;
            end else begin
               cmd.status_code = ST_OK;
               cmd.push        = 1'b1;
            end
         end
         S_FINISH: begin
            cmd.load_out = !stat.out_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   `KAFQ_ASSERT_IMPL(a_drop_needs_entry, clock, reset, cmd.drop, !stat.empty, "drop on empty queue")
   `KAFQ_ASSERT_IMPL(a_push_needs_room, clock, reset, cmd.push, !stat.full && !stat.cancelled, "push into full or cancelled queue")
   `KAFQ_ASSERT_IMPL(a_accept_only_idle, clock, reset, cmd.load_req, state_ff == S_IDLE, "request taken outside idle")

endmodule

@@ rtl/core/kafq_dp.sv @@
`include "keyframe_aware_frame_queue_top_assert.svh"

module kafq_dp
   import kafq_pkg::*;
#(
   parameter int QUEUE_DEPTH = KAFQ_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [30:0]   csr_wdata,
   input  logic [103:0]  req_tdata,
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [143:0]  rsp_tdata,
   output logic [2:0]    rsp_tuser,
   input  cmd_type       cmd,
   output stat_type      stat
);

   localparam int IDXW = $clog2(QUEUE_DEPTH);
   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(QUEUE_DEPTH - 1);
   localparam logic [CNTW-1:0] FULL_CNT = CNTW'(QUEUE_DEPTH);

   desc_type mem [QUEUE_DEPTH];

   logic [30:0]     max_bytes_ff;
   logic [7:0]      key_flag_ff;
   logic            cancelled_ff, cancelled_in;
   logic [IDXW-1:0] head_ff, head_in;
   logic [IDXW-1:0] tail_ff, tail_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [31:0]     total_ff, total_in;
   logic [1:0]      op_ff;
   desc_type        desc_ff;
   desc_type        rd_ff;
   desc_type        pop_ff;
   status_type      status_ff;
   logic [6:0]      dropped_ff;
   logic            rsp_valid_ff;
   logic [143:0]    rsp_data_ff;
   logic [2:0]      rsp_user_ff;

   function automatic logic [IDXW-1:0] next_slot(input logic [IDXW-1:0] i);
      next_slot = (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= MAX_BYTES_RESET;
         key_flag_ff  <= KEY_FLAG_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_BYTES: max_bytes_ff <= csr_wdata;
            CSR_KEY_FLAG:  key_flag_ff  <= csr_wdata[7:0];
            default:       max_bytes_ff <= max_bytes_ff;
         endcase
      end
   end

   // queue pointers and byte total
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      cancelled_in = cancelled_ff || cmd.cancel;
      if (cmd.drop || cmd.pop) begin
         total_in = total_ff - {8'd0, rd_ff.size};
         count_in = count_ff - 1'b1;
         if (count_ff == CNTW'(1)) begin
            head_in = '0;
            tail_in = '0;
         end else begin
            head_in = next_slot(head_ff);
         end
      end else if (cmd.push) begin
         total_in = total_ff + {8'd0, desc_ff.size};
         count_in = count_ff + 1'b1;
         tail_in  = next_slot(tail_ff);
      end else if (cmd.clear) begin
         head_in  = '0;
         tail_in  = '0;
         total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         cancelled_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         cancelled_ff <= cancelled_in;
      end
   end

   // descriptor memory; read address follows the next head so rd_ff tracks the head
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[tail_ff] <= desc_ff;
      end
      rd_ff <= mem[head_in];
   end

   // per-request working registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff      <= req_tuser;
         desc_ff    <= desc_type'(req_tdata);
         pop_ff     <= '0;
         dropped_ff <= '0;
         status_ff  <= ST_OK;
      end else begin
         if (cmd.pop) begin
            pop_ff <= rd_ff;
         end
         if (cmd.drop && dropped_ff != 7'h7f) begin
            dropped_ff <= dropped_ff + 1'b1;
         end
         if (cmd.set_status) begin
            status_ff <= cmd.status_code;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= {1'b0, total_ff, dropped_ff, pop_ff};
         rsp_user_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign stat.op         = op_ff;
   assign stat.cancelled  = cancelled_ff;
   assign stat.empty      = (count_ff == '0);
   assign stat.full       = (count_ff >= FULL_CNT);
   assign stat.over_limit = (total_ff >= {1'b0, max_bytes_ff});
   assign stat.head_key   = (rd_ff.flag == key_flag_ff);
   assign stat.out_busy   = rsp_valid_ff && !rsp_tready;

   `KAFQ_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= FULL_CNT, "entry count past depth")
   `KAFQ_ASSERT_IMPL(a_empty_ptrs, clock, reset, count_ff == '0, head_ff == '0 && tail_ff == '0, "empty queue with stray pointers")
   `KAFQ_ASSERT_IMPL(a_empty_total, clock, reset, count_ff == '0, total_ff == '0, "empty queue with nonzero byte total")
   `KAFQ_ASSERT_IMPL(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_tready, !cmd.load_out, "result overwritten while stalled")

endmodule

@@ rtl/core/keyframe_aware_frame_queue_top.sv @@
// Keyframe-aware frame queue. Holds up to QUEUE_DEPTH frame descriptors
// (handle, size, kind, flag, time stamp) in a ring with a running byte total.
// Each request transfer (push, pop or cancel, selected by req_tuser) yields
// exactly one response transfer carrying a status on rsp_tuser and the popped
// descriptor, drop count and byte total on rsp_tdata. A push into a non-empty
// queue whose total has reached max_queued_bytes first discards head entries
// until the queue is empty or the head is a key frame (flag equal to
// key_flag_value) and the total is below the limit. One request is in flight
// at a time. A push passes from its transfer through accept, check, commit
// and result load steps; a pop, cancel or unused opcode has no commit step.
// A push that starts a drop walk adds a drop step per entry dropped plus one
// more in which the walk finds a key frame under the limit or an empty queue,
// since the walk reads the descriptor memory at the head, one entry per cycle.
// A finished response sits in an output register, so the next request can be
// taken while it waits; only loading a new response waits for the old one to
// go out, which stretches the result load step. Registers must be written
// through csr_we/csr_index/csr_wdata while idle; the block does not enforce it.

module keyframe_aware_frame_queue_top
   import kafq_pkg::*;
#(
   parameter int QUEUE_DEPTH = KAFQ_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   // config write port
   input  logic         csr_we,
   input  logic         csr_index,   // 0 max_queued_bytes, 1 key_flag_value
   input  logic [30:0]  csr_wdata,
   // request
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,   // payload_handle, frame_size, frame_kind,
                                     // frame_flag, timestamp
   input  logic [1:0]   req_tuser,   // opcode
   // response
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata,   // out_handle, out_size, out_kind, out_flag,
                                     // out_timestamp, dropped_count,
                                     // queued_bytes, one pad bit
   output logic [2:0]   rsp_tuser    // status
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer: decides drop walk, push/pop commit and result load
   kafq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // descriptor memory, pointers, byte total and response register
   kafq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

@@ verif/tb_keyframe_aware_frame_queue_top.sv @@
`timescale 1ns / 100ps

module tb_keyframe_aware_frame_queue_top
   import kafq_pkg::*;
();

   localparam int DEPTH = KAFQ_DEPTH_DEFAULT;
   // opcode 3 is a no-op in the block
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // cycles with no transfer on either side before the run is called hung
   localparam int STALL_LIMIT = 4000;

   // one response as the checker sees it
   typedef struct packed {
      status_type  status;
      desc_type    frame;
      logic [6:0]  dropped;
      logic [31:0] total;
   } queue_result_type;

   // one row of the directed table; typed rows carry their own answer
   typedef struct packed {
      logic [1:0]       op;
      desc_type         frame;
      bit               typed;
      queue_result_type result;
   } table_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_we = 1'b0;
   logic         csr_index = 1'b0;
   logic [30:0]  csr_wdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;   // handle, size, kind, flag, timestamp
   logic [1:0]   req_tuser = '0;   // opcode
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;        // handle, size, kind, flag, timestamp,
                                   // dropped count, byte total, pad
   logic [2:0]   rsp_tuser;        // status

   keyframe_aware_frame_queue_top DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow of the frame queue: ring, pointers, byte total, cancel flag and
   // the two registers. Stepped once per accepted request transfer.
   // ---------------------------------------------------------------------
   desc_type    frame_ring [DEPTH];
   int unsigned head_q, tail_q, count_q;
   logic [31:0] total_q;
   bit          cancel_q;
   logic [30:0] limit_q;
   logic [7:0]  key_q;

   // run statistics for the closing summary
   int unsigned push_count, drop_total, full_count, reject_count;
   int unsigned issued_count, resp_count, config_count;

   queue_result_type pending_results[$];
   table_row_type    frame_table[$];
   int               mismatch_count;
   int               send_idle_pct, recv_idle_pct;

   function automatic void drop_head();
      total_q = total_q - 32'(frame_ring[head_q].size);
      head_q  = (head_q + 1) % DEPTH;
      count_q--;
      // emptied ring restarts at slot zero
      if (count_q == 0) begin
         head_q = 0;
         tail_q = 0;
      end
   endfunction

   function automatic queue_result_type predict_frame_op(logic [1:0] op, desc_type frame);
      queue_result_type r;
      int unsigned      drops;
      r = '0;
      r.status = ST_OK;
      drops = 0;
      case (op)
         OP_PUSH: begin
            if (cancel_q) begin
               r.status = ST_REJECTED;
               reject_count++;
            end else begin
               // over the limit: walk the head back to a key frame under the limit
               if (count_q > 0 && total_q >= 32'(limit_q)) begin
                  while (count_q > 0 &&
                         (frame_ring[head_q].flag != key_q || total_q >= 32'(limit_q))) begin
                     drop_head();
                     drops++;
                  end
               end
               if (count_q >= DEPTH) begin
                  r.status = ST_FULL;
                  full_count++;
               end else begin
                  frame_ring[tail_q] = frame;
                  total_q = total_q + 32'(frame.size);
                  tail_q  = (tail_q + 1) % DEPTH;
                  count_q++;
                  push_count++;
               end
            end
         end
         OP_POP: begin
            if (count_q == 0) begin
               if (cancel_q) begin
                  // cancelled and drained: clear, cancel stays set
                  r.status = ST_CANCELLED;
                  head_q  = 0;
                  tail_q  = 0;
                  total_q = '0;
               end else begin
                  r.status = ST_EMPTY;
               end
            end else begin
               r.frame = frame_ring[head_q];
               drop_head();
            end
         end
         OP_CANCEL: cancel_q = 1'b1;
         default: ;
      endcase
      drop_total += drops;
      r.dropped = (drops > 127) ? 7'd127 : 7'(drops);
      r.total   = total_q;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Response side: random backpressure, every response transfer checked
   // against the oldest expectation.
   // ---------------------------------------------------------------------
   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch, response %0d, %s: expected 0x%0h, got 0x%0h",
                     resp_count, name, want, got);
      end
   endfunction

   task automatic check_response();
      queue_result_type want;
      desc_type         got;
      if (pending_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("response transfer with nothing outstanding, status 0x%0h", rsp_tuser);
      end else begin
         want = pending_results.pop_front();
         got  = rsp_tdata[103:0];
         compare_field("status", 32'(want.status), 32'(rsp_tuser));
         compare_field("handle", want.frame.handle, got.handle);
         compare_field("size", 32'(want.frame.size), 32'(got.size));
         compare_field("kind", 32'(want.frame.kind), 32'(got.kind));
         compare_field("flag", 32'(want.frame.flag), 32'(got.flag));
         compare_field("timestamp", want.frame.timestamp, got.timestamp);
         compare_field("dropped count", 32'(want.dropped), 32'(rsp_tdata[110:104]));
         compare_field("queued bytes", want.total, rsp_tdata[142:111]);
      end
      resp_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_response();
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // watchdog: ends the run when nothing moves for too long
   initial begin : watchdog
      int stall_cycles;
      stall_cycles = 0;
      do begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end while (stall_cycles < STALL_LIMIT);
      $display("timeout: no transfer for %0d cycles, %0d responses outstanding",
               STALL_LIMIT, pending_results.size());
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // one request transfer; valid stays up afterwards for back-to-back items
   task automatic issue(logic [1:0] op, desc_type frame, bit typed,
                        queue_result_type typed_result);
      queue_result_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= frame;
      do @(posedge clock); while (!req_tready);
      predicted = predict_frame_op(op, frame);
      pending_results.push_back(typed ? typed_result : predicted);
      issued_count++;
   endtask

   // stop sending and wait until every response is back and the block is idle
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // both registers, back to back, while idle
   task automatic reconfigure(logic [30:0] limit, logic [7:0] key);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_MAX_BYTES;
      csr_wdata <= limit;
      @(posedge clock);
      csr_index <= CSR_KEY_FLAG;
      csr_wdata <= {23'd0, key};
      @(posedge clock);
      csr_we  <= 1'b0;
      limit_q = limit;
      key_q   = key;
      config_count++;
   endtask

   task automatic random_items(int count, int push_pct, int pop_pct, int cancel_pct,
                               int unsigned size_max, int key_pct);
      int         pick;
      logic [1:0] op;
      desc_type   frame;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < push_pct)
            op = OP_PUSH;
         else if (pick < push_pct + pop_pct)
            op = OP_POP;
         else if (pick < push_pct + pop_pct + cancel_pct)
            op = OP_CANCEL;
         else
            op = OP_UNUSED;
         frame.handle    = $urandom;
         frame.size      = 24'($urandom_range(0, size_max));
         frame.kind      = 8'($urandom_range(0, 255));
         frame.timestamp = $urandom;
         if ($urandom_range(0, 99) < key_pct)
            frame.flag = key_q;
         else
            frame.flag = 8'($urandom_range(0, 255));
         issue(op, frame, 1'b0, '0);
      end
   endtask

   task automatic run_rows(int first, int last);
      for (int i = first; i <= last; i++)
         issue(frame_table[i].op, frame_table[i].frame, frame_table[i].typed,
               frame_table[i].result);
   endtask

   function automatic desc_type frame_of(logic [31:0] handle, logic [23:0] size,
                                         logic [7:0] kind, logic [7:0] flag,
                                         logic [31:0] stamp);
      desc_type f;
      f.handle    = handle;
      f.size      = size;
      f.kind      = kind;
      f.flag      = flag;
      f.timestamp = stamp;
      return f;
   endfunction

   function automatic queue_result_type result_of(status_type status, desc_type frame,
                                                  logic [31:0] total);
      queue_result_type r;
      r.status  = status;
      r.frame   = frame;
      r.dropped = '0;
      r.total   = total;
      return r;
   endfunction

   function automatic void add_checked(logic [1:0] op, desc_type frame);
      frame_table.push_back('{op, frame, 1'b0, '0});
   endfunction

   function automatic void add_typed(logic [1:0] op, desc_type frame,
                                     queue_result_type result);
      frame_table.push_back('{op, frame, 1'b1, result});
   endfunction

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      desc_type    zero_frame, ones_frame;
      int          opening_last, cancel_last;
      int unsigned limit;

      zero_frame = '0;
      ones_frame = '1;
      head_q  = 0;
      tail_q  = 0;
      count_q = 0;
      total_q = '0;
      cancel_q = 1'b0;
      limit_q = MAX_BYTES_RESET;
      key_q   = KEY_FLAG_RESET;
      send_idle_pct = 20;
      recv_idle_pct = 69;

      // opening table, reset register values (limit 1 MiB, key flag 1)
      add_typed(OP_POP, zero_frame, result_of(ST_EMPTY, '0, '0));
      add_typed(OP_UNUSED, ones_frame, result_of(ST_OK, '0, '0));
      add_typed(OP_PUSH, zero_frame, result_of(ST_OK, '0, '0));
      add_typed(OP_PUSH, ones_frame, result_of(ST_OK, '0, 32'h00FF_FFFF));
      add_typed(OP_POP, zero_frame, result_of(ST_OK, zero_frame, 32'h00FF_FFFF));
      add_typed(OP_POP, zero_frame, result_of(ST_OK, ones_frame, '0));
      add_typed(OP_POP, zero_frame, result_of(ST_EMPTY, '0, '0));
      // key then non-key over the limit; next push walks the ring empty
      add_checked(OP_PUSH, frame_of(32'h1000_0001, 24'd600000, 8'h10, KEY_FLAG_RESET, 32'd100));
      add_checked(OP_PUSH, frame_of(32'h1000_0002, 24'd600000, 8'h20, 8'h02, 32'd200));
      add_checked(OP_PUSH, frame_of(32'h1000_0003, 24'd100, 8'h30, 8'h00, 32'd300));
      // two key frames; the drop walk stops on the second one
      add_checked(OP_PUSH, frame_of(32'h1000_0004, 24'd500000, 8'h40, KEY_FLAG_RESET, 32'd400));
      add_checked(OP_PUSH, frame_of(32'h1000_0005, 24'd600000, 8'h50, KEY_FLAG_RESET, 32'd500));
      add_checked(OP_PUSH, frame_of(32'h1000_0006, 24'd7, 8'h60, 8'hFE, 32'd600));
      add_checked(OP_PUSH, frame_of(32'hA5A5_A5A5, 24'h5A5A5A, 8'hA5, 8'h5A, 32'h5A5A_5A5A));
      add_checked(OP_PUSH, frame_of(32'h5A5A_5A5A, 24'hA5A5A5, 8'h5A, 8'hA5, 32'hA5A5_A5A5));
      add_checked(OP_POP, zero_frame);
      add_checked(OP_POP, zero_frame);
      add_checked(OP_UNUSED, zero_frame);
      add_checked(OP_POP, zero_frame);
      add_checked(OP_POP, zero_frame);
      opening_last = frame_table.size() - 1;
      // cancel lead-in: repeated cancel, then a rejected push
      add_checked(OP_CANCEL, zero_frame);
      add_checked(OP_CANCEL, ones_frame);
      add_checked(OP_PUSH, ones_frame);
      cancel_last = frame_table.size() - 1;
      // once drained: cancelled-and-cleared pops, rejects, no-ops
      add_typed(OP_POP, zero_frame, result_of(ST_CANCELLED, '0, '0));
      add_typed(OP_PUSH, ones_frame, result_of(ST_REJECTED, '0, '0));
      add_typed(OP_CANCEL, zero_frame, result_of(ST_OK, '0, '0));
      add_typed(OP_POP, ones_frame, result_of(ST_CANCELLED, '0, '0));
      add_typed(OP_UNUSED, zero_frame, result_of(ST_OK, '0, '0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      run_rows(0, opening_last);

      // largest limit: no drops, push-heavy traffic fills the ring
      reconfigure(31'h7FFF_FFFF, 8'hFF);
      random_items(400, 75, 20, 0, 24'hFF_FFFF, 10);

      // small limit, frequent drop walks
      reconfigure(31'd4000, 8'($urandom_range(0, 255)));
      random_items(400, 55, 42, 0, 400, 35);

      send_idle_pct = 69;
      recv_idle_pct = 20;
      // zero limit: any push into a non-empty queue empties it first
      reconfigure(31'd0, 8'h80);
      random_items(250, 60, 37, 0, 1000, 50);

      // limit of one with key flag zero; zero-size frames keep the total under it
      reconfigure(31'd1, 8'h00);
      random_items(250, 60, 37, 0, 3, 50);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int p = 0; p < 4; p++) begin
         limit = $urandom_range(1, 1 << 22);
         reconfigure(31'(limit), 8'($urandom_range(0, 255)));
         random_items(100, 55, 42, 0, limit / 4, 40);
      end

      // cancel is sticky until reset, so it closes the run
      run_rows(opening_last + 1, cancel_last);
      while (count_q > 0)
         issue(OP_POP, zero_frame, 1'b0, '0);
      run_rows(cancel_last + 1, frame_table.size() - 1);
      random_items(40, 40, 40, 15, 1000, 30);

      settle();
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0) begin
         mismatch_count++;
         $display("%0d responses never arrived", pending_results.size());
      end

      $display("ran %0d requests and %0d responses across %0d register settings",
               issued_count, resp_count, config_count + 1);
      $display("stored %0d frames, dropped %0d, %0d full-ring and %0d post-cancel rejects",
               push_count, drop_total, full_count, reject_count);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/kafq_pkg.sv
rtl/core/kafq_ctrl.sv
rtl/core/kafq_dp.sv
rtl/core/keyframe_aware_frame_queue_top.sv
verif/tb_keyframe_aware_frame_queue_top.sv
